// ===== rtl/sbn_pkg.sv =====
// Shared constants and types of the slotted B-tree node engine.
`default_nettype none
package sbn_pkg;
	localparam int SLOTS = 8;
	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int KEY_W = 64;
	localparam int PTR_W = 64;
	localparam int CNT_W = 4;
	localparam int STAT_W = 2;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_FOUND = 2'd2;
	localparam logic [STAT_W-1:0] ST_ABSENT = 2'd3;

	typedef struct packed {
		logic ins;
		logic [IW-1:0] pos;
		logic [IW-1:0] rd_idx;
	} slot_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/sbn_if.sv =====
// Request and response channel interfaces of the node engine.
`default_nettype none
interface sbn_req_if;
	logic valid;
	logic ready;
	logic cmd;
	logic signed [sbn_pkg::KEY_W-1:0] key;
	logic [sbn_pkg::PTR_W-1:0] child_value;
	logic has_left;
	logic [sbn_pkg::PTR_W-1:0] left_child;

	modport source(output valid, cmd, key, child_value, has_left, left_child, input ready);
	modport sink(input valid, cmd, key, child_value, has_left, left_child, output ready);
endinterface

interface sbn_rsp_if;
	logic valid;
	logic ready;
	logic [sbn_pkg::STAT_W-1:0] status;
	logic [sbn_pkg::PTR_W-1:0] result_ptr;
	logic [sbn_pkg::CNT_W-1:0] entry_count;

	modport source(output valid, status, result_ptr, entry_count, input ready);
	modport sink(input valid, status, result_ptr, entry_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/sbn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sbn_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/sbn_slots.sv =====
// Sorted slot array: record order, insert shift and lowest free record.
`default_nettype none
module sbn_slots (
	input  wire logic                    clk,
	input  wire sbn_pkg::slot_ctl_t      ctl,
	input  wire logic [sbn_pkg::CW-1:0]  count,
	output logic      [sbn_pkg::IW-1:0]  rd_rec,
	output logic      [sbn_pkg::IW-1:0]  free_rec
);
	logic [sbn_pkg::IW-1:0] order_q [sbn_pkg::SLOTS];
	logic [sbn_pkg::SLOTS-1:0] used;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (ctl.pos == '0) begin
				order_q[0] <= free_rec;
			end
			for (int i = 1; i < sbn_pkg::SLOTS; i++) begin
				if (sbn_pkg::IW'(i) == ctl.pos) begin
					order_q[i] <= free_rec;
				end else if (sbn_pkg::IW'(i) > ctl.pos) begin
					order_q[i] <= order_q[i-1];
				end
			end
		end
	end

	assign rd_rec = order_q[ctl.rd_idx];

	always_comb begin
		used = '0;
		for (int j = 0; j < sbn_pkg::SLOTS; j++) begin
			if (sbn_pkg::CW'(j) < count) begin
				used[order_q[j]] = 1'b1;
			end
		end
		free_rec = '0;
		for (int i = sbn_pkg::SLOTS - 1; i >= 0; i--) begin
			if (!used[i]) begin
				free_rec = sbn_pkg::IW'(i);
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/slotted_btree_node_engine.sv =====
// Top level of the slotted B-tree node engine: sequencer, record stores, result register.
// Usage:
//   req carries one command per transfer: insert (key, child_value, optional left_child
//   when has_left) or search (key). rsp returns one result per command: status,
//   result_ptr and entry_count after the command.
//   cfg_we/cfg_wdata write node_is_leaf (leaf: exact match, internal: child select);
//   write it only while no command is in flight.
//   A command runs alone through one key compare unit: a binary search over the slot
//   array runs each probe as a slot read and record read, then a compare, at most
//   ceil(log2(SLOTS+1)) probes. A search on an internal node whose key is not below
//   every stored key then reads the child pointer (S_PREAD, S_PCAP); a leaf hit ends
//   the search at once. An insert writes the left child first with has_left, then the
//   record; an insert on a full page goes straight to the result without a search.
//   req.ready is high only while idle; the next command can be taken in the cycle after the
//   result is loaded into the output register.
//   A stalled rsp holds the result; a finished command waits until the register frees.
//   Reset empties the page, clears leftmost_child and sets node_is_leaf.
`default_nettype none
module slotted_btree_node_engine (
	input  wire logic clk,
	input  wire logic arst_n,
	sbn_req_if.sink   req,
	sbn_rsp_if.source rsp,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata
);
	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_PROBE = 8'b0000_0010,
		S_CMP   = 8'b0000_0100,
		S_PREAD = 8'b0000_1000,
		S_PCAP  = 8'b0001_0000,
		S_WLEFT = 8'b0010_0000,
		S_WREC  = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [sbn_pkg::CW-1:0] cnt_q;
	logic leaf_q;
	logic [sbn_pkg::PTR_W-1:0] leftmost_q;
	logic rsp_valid_q;

	logic cmd_q;
	logic signed [sbn_pkg::KEY_W-1:0] key_q;
	logic [sbn_pkg::PTR_W-1:0] child_q;
	logic has_left_q;
	logic [sbn_pkg::PTR_W-1:0] left_q;
	logic [sbn_pkg::CW-1:0] lb_q;
	logic [sbn_pkg::CW-1:0] hi_q;
	logic [sbn_pkg::STAT_W-1:0] res_status_q;
	logic [sbn_pkg::PTR_W-1:0] res_ptr_q;
	logic [sbn_pkg::STAT_W-1:0] rsp_status_q;
	logic [sbn_pkg::PTR_W-1:0] rsp_ptr_q;
	logic [sbn_pkg::CW-1:0] rsp_count_q;

	logic [sbn_pkg::CW:0] mid_sum;
	logic [sbn_pkg::IW-1:0] mid;
	logic [sbn_pkg::CW-1:0] hi_m1;
	logic [sbn_pkg::CW-1:0] lb_m1;
	logic more;
	logic full;
	logic out_free;
	sbn_pkg::slot_ctl_t slot_ctl;
	logic [sbn_pkg::IW-1:0] rd_rec;
	logic [sbn_pkg::IW-1:0] free_rec;
	logic signed [sbn_pkg::KEY_W-1:0] key_rd;
	logic [sbn_pkg::PTR_W-1:0] ptr_rd;
	logic key_lt;
	logic leaf_hit;
	logic ptr_we;
	logic [sbn_pkg::IW-1:0] ptr_waddr;
	logic [sbn_pkg::PTR_W-1:0] ptr_wdata;

	assign mid_sum = {1'b0, lb_q} + {1'b0, hi_q} - (sbn_pkg::CW + 1)'(1);
	assign mid = mid_sum[sbn_pkg::IW:1];
	assign hi_m1 = hi_q - sbn_pkg::CW'(1);
	assign lb_m1 = lb_q - sbn_pkg::CW'(1);
	assign more = lb_q < hi_q;
	assign full = cnt_q == sbn_pkg::CW'(sbn_pkg::SLOTS);
	assign out_free = !rsp_valid_q || rsp.ready;
	assign key_lt = key_q < key_rd;
	assign leaf_hit = leaf_q && (cmd_q == sbn_pkg::CMD_SEARCH) && (key_q == key_rd);

	always_comb begin
		slot_ctl.ins = state_q == S_WREC;
		slot_ctl.pos = lb_q[sbn_pkg::IW-1:0];
		if (state_q == S_PREAD) begin
			slot_ctl.rd_idx = hi_m1[sbn_pkg::IW-1:0];
		end else if (state_q == S_WLEFT) begin
			slot_ctl.rd_idx = lb_m1[sbn_pkg::IW-1:0];
		end else begin
			slot_ctl.rd_idx = mid;
		end
	end

	assign ptr_we = (state_q == S_WREC) || ((state_q == S_WLEFT) && (lb_q != '0));
	assign ptr_waddr = (state_q == S_WREC) ? free_rec : rd_rec;
	assign ptr_wdata = (state_q == S_WREC) ? child_q : left_q;

	sbn_slots u_slots (
		.clk      (clk),
		.ctl      (slot_ctl),
		.count    (cnt_q),
		.rd_rec   (rd_rec),
		.free_rec (free_rec)
	);

	sbn_ram #(
		.WIDTH (sbn_pkg::KEY_W),
		.DEPTH (sbn_pkg::SLOTS)
	) u_key_ram (
		.clk   (clk),
		.we    (state_q == S_WREC),
		.waddr (free_rec),
		.wdata (key_q),
		.raddr (rd_rec),
		.rdata (key_rd)
	);

	sbn_ram #(
		.WIDTH (sbn_pkg::PTR_W),
		.DEPTH (sbn_pkg::SLOTS)
	) u_ptr_ram (
		.clk   (clk),
		.we    (ptr_we),
		.waddr (ptr_waddr),
		.wdata (ptr_wdata),
		.raddr (rd_rec),
		.rdata (ptr_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			leaf_q <= 1'b1;
			leftmost_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				leaf_q <= cfg_wdata;
			end
			if (state_q == S_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= (req.cmd == sbn_pkg::CMD_INSERT && full) ? S_OUT : S_PROBE;
					end
				end
				S_PROBE: begin
					if (more) begin
						state_q <= S_CMP;
					end else if (cmd_q == sbn_pkg::CMD_INSERT) begin
						state_q <= has_left_q ? S_WLEFT : S_WREC;
					end else if (!leaf_q && hi_q != '0) begin
						state_q <= S_PREAD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_CMP: begin
					state_q <= (!key_lt && leaf_hit) ? S_OUT : S_PROBE;
				end
				S_PREAD: begin
					state_q <= S_PCAP;
				end
				S_PCAP: begin
					state_q <= S_OUT;
				end
				S_WLEFT: begin
					if (lb_q == '0) begin
						leftmost_q <= left_q;
					end
					state_q <= S_WREC;
				end
				S_WREC: begin
					cnt_q <= cnt_q + sbn_pkg::CW'(1);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					cmd_q <= req.cmd;
					key_q <= req.key;
					child_q <= req.child_value;
					has_left_q <= req.has_left;
					left_q <= req.left_child;
					lb_q <= '0;
					hi_q <= cnt_q;
					res_status_q <= sbn_pkg::ST_FULL;
					res_ptr_q <= '0;
				end
			end
			S_PROBE: begin
				if (!more) begin
					if (cmd_q == sbn_pkg::CMD_INSERT) begin
						res_status_q <= sbn_pkg::ST_INSERTED;
					end else if (leaf_q) begin
						res_status_q <= sbn_pkg::ST_ABSENT;
					end else begin
						res_status_q <= sbn_pkg::ST_FOUND;
						res_ptr_q <= leftmost_q;
					end
				end
			end
			S_CMP: begin
				if (key_lt) begin
					hi_q <= sbn_pkg::CW'(mid);
				end else if (leaf_hit) begin
					res_status_q <= sbn_pkg::ST_FOUND;
					res_ptr_q <= ptr_rd;
				end else begin
					lb_q <= sbn_pkg::CW'(mid) + sbn_pkg::CW'(1);
				end
			end
			S_PCAP: begin
				res_ptr_q <= ptr_rd;
			end
			S_OUT: begin
				if (out_free) begin
					rsp_status_q <= res_status_q;
					rsp_ptr_q <= res_ptr_q;
					rsp_count_q <= cnt_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign req.ready = state_q == S_IDLE;
	assign rsp.valid = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.result_ptr = rsp_ptr_q;
	assign rsp.entry_count = sbn_pkg::CNT_W'(rsp_count_q);
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the slotted B-tree node engine: directed table, random items, prediction.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sbn_pkg::*;

	localparam int SETTLE_CYCLES = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RAND_PHASES = 4;
	localparam int PHASE_ITEMS = 125;
	localparam logic signed [KEY_W-1:0] KEY_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic [PTR_W-1:0] PTR_ONES = {PTR_W{1'b1}};

	typedef enum logic {ROW_ITEM, ROW_LEAF} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic leaf_val;
		logic cmd;
		logic signed [KEY_W-1:0] key;
		logic [PTR_W-1:0] child_value;
		logic has_left;
		logic [PTR_W-1:0] left_child;
		logic fixed;
		logic [STAT_W-1:0] exp_status;
		logic [PTR_W-1:0] exp_ptr;
		logic [CNT_W-1:0] exp_count;
	} page_row_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [PTR_W-1:0] ptr;
		logic [CNT_W-1:0] count;
	} page_res_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	sbn_req_if req_ch();
	sbn_rsp_if rsp_ch();

	slotted_btree_node_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// page shadow
	logic leaf_mode = 1'b1;
	logic [CW-1:0] held = '0;
	logic [IW-1:0] order [SLOTS];
	logic signed [KEY_W-1:0] rkey [SLOTS];
	logic [PTR_W-1:0] rptr [SLOTS];
	logic [PTR_W-1:0] leftmost = '0;

	page_res_t awaited [$];
	page_row_t dir_table [$];
	page_row_t cur_row;
	int errors = 0;
	int quiet_cycles = 0;
	int send_burst = 0;
	int ready_hold = 0;
	int roll;

	always #2 clk = ~clk;

	function automatic page_res_t node_step(input page_row_t r);
		page_res_t res;
		bit used [SLOTS];
		logic signed [KEY_W-1:0] k;
		logic signed [KEY_W-1:0] probe;
		int cnt, rec, pos, i, lb, ub, m;
		bit hit;
		res = '0;
		k = r.key;
		cnt = held;
		if (r.cmd == CMD_INSERT) begin
			if (cnt >= SLOTS) begin
				res.status = ST_FULL;
			end else begin
				for (i = 0; i < SLOTS; i++) used[i] = 1'b0;
				for (i = 0; i < cnt; i++) used[order[i]] = 1'b1;
				rec = 0;
				for (i = SLOTS - 1; i >= 0; i--) if (!used[i]) rec = i;
				pos = cnt;
				for (i = cnt - 1; i >= 0; i--) if (k < rkey[order[i]]) pos = i;
				if (r.has_left) begin
					if (pos > 0) rptr[order[pos - 1]] = r.left_child;
					else leftmost = r.left_child;
				end
				rkey[rec] = k;
				rptr[rec] = r.child_value;
				for (i = cnt - 1; i >= pos; i--) order[i + 1] = order[i];
				order[pos] = rec[IW-1:0];
				held = CW'(cnt + 1);
				res.status = ST_INSERTED;
			end
		end else if (leaf_mode) begin
			lb = 0;
			ub = cnt - 1;
			hit = 1'b0;
			res.status = ST_ABSENT;
			while (lb <= ub && !hit) begin
				m = (lb + ub) / 2;
				probe = rkey[order[m]];
				if (k < probe) begin
					ub = m - 1;
				end else if (k == probe) begin
					hit = 1'b1;
					res.ptr = rptr[order[m]];
					res.status = ST_FOUND;
				end else begin
					lb = m + 1;
				end
			end
		end else begin
			lb = 0;
			ub = cnt - 1;
			while (lb <= ub) begin
				m = (lb + ub) / 2;
				probe = rkey[order[m]];
				if (k < probe) ub = m - 1;
				else lb = m + 1;
			end
			res.ptr = (ub >= 0) ? rptr[order[ub]] : leftmost;
			res.status = ST_FOUND;
		end
		res.count = held;
		return res;
	endfunction

	function automatic page_row_t item_row(input logic cmd, input logic signed [KEY_W-1:0] key,
			input logic [PTR_W-1:0] child, input logic hl, input logic [PTR_W-1:0] left);
		page_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.cmd = cmd;
		r.key = key;
		r.child_value = child;
		r.has_left = hl;
		r.left_child = left;
		return r;
	endfunction

	function automatic page_row_t checked_row(input page_row_t r, input logic [STAT_W-1:0] st,
			input logic [PTR_W-1:0] ptr, input logic [CNT_W-1:0] cnt);
		page_row_t c;
		c = r;
		c.fixed = 1'b1;
		c.exp_status = st;
		c.exp_ptr = ptr;
		c.exp_count = cnt;
		return c;
	endfunction

	function automatic page_row_t leaf_row(input logic v);
		page_row_t r;
		r = '0;
		r.kind = ROW_LEAF;
		r.leaf_val = v;
		return r;
	endfunction

	function automatic void add_row(input page_row_t r);
		dir_table.insert(dir_table.size(), r);
	endfunction

	function automatic page_row_t random_item();
		page_row_t r;
		int pick;
		r = item_row(($urandom_range(0, 99) < 12) ? CMD_INSERT : CMD_SEARCH,
			{$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
			{$urandom, $urandom});
		pick = $urandom_range(0, 99);
		if (pick < 55 && held > 0) begin
			r.key = rkey[order[$urandom_range(0, held - 1)]];
			if (pick < 15) r.key = r.key + 1;
			else if (pick < 25) r.key = r.key - 1;
		end else if (pick < 70) begin
			case ($urandom_range(0, 3))
				0: r.key = KEY_MIN;
				1: r.key = KEY_MAX;
				2: r.key = '0;
				default: r.key = -1;
			endcase
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		if (send_burst > 0) begin
			send_burst--;
			return 0;
		end
		p = $urandom_range(0, 99);
		if (p < 3) begin
			send_burst = $urandom_range(10, 30);
			return 0;
		end
		if (p < 50) return 0;
		if (p < 85) return $urandom_range(1, 3);
		if (p < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic send_item(input page_row_t r);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cur_row = r;
		req_ch.cmd = r.cmd;
		req_ch.key = r.key;
		req_ch.child_value = r.child_value;
		req_ch.has_left = r.has_left;
		req_ch.left_child = r.left_child;
		req_ch.valid = 1'b1;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (awaited.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_leaf(input logic v);
		wait_drained();
		cfg_wdata = v;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// response backpressure
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 60) begin
				rsp_ch.ready = 1'b1;
				ready_hold = $urandom_range(0, 6);
			end else if (roll < 62) begin
				rsp_ch.ready = 1'b1;
				ready_hold = $urandom_range(50, 100);
			end else if (roll < 90) begin
				rsp_ch.ready = 1'b0;
				ready_hold = $urandom_range(0, 2);
			end else if (roll < 97) begin
				rsp_ch.ready = 1'b0;
				ready_hold = $urandom_range(3, 10);
			end else begin
				rsp_ch.ready = 1'b0;
				ready_hold = $urandom_range(20, 40);
			end
		end
	end

	always @(posedge clk) begin
		page_res_t got;
		page_res_t want;
		if (arst_n) begin
			if (cfg_we) leaf_mode = cfg_wdata;
			if (req_ch.valid && req_ch.ready) begin
				want = node_step(cur_row);
				if (cur_row.fixed) want = {cur_row.exp_status, cur_row.exp_ptr, cur_row.exp_count};
				awaited.insert(awaited.size(), want);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = {rsp_ch.status, rsp_ch.result_ptr, rsp_ch.entry_count};
				if (awaited.size() == 0) begin
					errors++;
					$display("%0t unexpected transfer: status %0d ptr %h count %0d",
						$time, got.status, got.ptr, got.count);
				end else begin
					want = awaited.pop_front();
					if (got.status !== want.status) begin
						errors++;
						$display("%0t status: expected %0d actual %0d",
							$time, want.status, got.status);
					end
					if (got.ptr !== want.ptr) begin
						errors++;
						$display("%0t result_ptr: expected %h actual %h",
							$time, want.ptr, got.ptr);
					end
					if (got.count !== want.count) begin
						errors++;
						$display("%0t entry_count: expected %0d actual %0d",
							$time, want.count, got.count);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL slotted_btree_node_engine");
			$finish;
		end
	end

	initial begin
		int ph, n;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_INSERT;
		req_ch.key = '0;
		req_ch.child_value = '0;
		req_ch.has_left = 1'b0;
		req_ch.left_child = '0;
		rsp_ch.ready = 1'b0;
		cur_row = '0;

		add_row(checked_row(item_row(CMD_SEARCH, 0, PTR_ONES, 1'b1, PTR_ONES),
			ST_ABSENT, '0, 4'd0));
		add_row(leaf_row(1'b0));
		add_row(checked_row(item_row(CMD_SEARCH, 5, 0, 1'b0, 0), ST_FOUND, '0, 4'd0));
		add_row(checked_row(item_row(CMD_INSERT, 100, 64'h1111, 1'b1, 64'hAAAA),
			ST_INSERTED, '0, 4'd1));
		add_row(item_row(CMD_SEARCH, -5, 0, 1'b0, 0));
		add_row(checked_row(item_row(CMD_INSERT, KEY_MIN, 64'h2222, 1'b1, 64'hBBBB),
			ST_INSERTED, '0, 4'd2));
		add_row(checked_row(item_row(CMD_INSERT, KEY_MAX, 0, 1'b1, 64'hCCCC),
			ST_INSERTED, '0, 4'd3));
		add_row(checked_row(item_row(CMD_INSERT, 100, 64'h3333, 1'b1, PTR_ONES),
			ST_INSERTED, '0, 4'd4));
		add_row(checked_row(item_row(CMD_INSERT, -1, 64'h4444, 1'b0, PTR_ONES),
			ST_INSERTED, '0, 4'd5));
		add_row(checked_row(item_row(CMD_INSERT, 0, PTR_ONES, 1'b1, 0),
			ST_INSERTED, '0, 4'd6));
		add_row(checked_row(item_row(CMD_INSERT, 100, 64'h5555, 1'b0, 0),
			ST_INSERTED, '0, 4'd7));
		add_row(checked_row(item_row(CMD_INSERT, 7, 64'h6666, 1'b1, 64'h7777),
			ST_INSERTED, '0, 4'd8));
		add_row(checked_row(item_row(CMD_INSERT, 50, 64'h8888, 1'b1, 64'h9999),
			ST_FULL, '0, 4'd8));
		add_row(item_row(CMD_SEARCH, KEY_MIN, 0, 1'b0, 0));
		add_row(item_row(CMD_SEARCH, KEY_MAX, 0, 1'b0, 0));
		add_row(item_row(CMD_SEARCH, 99, 0, 1'b0, 0));
		add_row(item_row(CMD_SEARCH, -2, 0, 1'b0, 0));
		add_row(leaf_row(1'b1));
		add_row(checked_row(item_row(CMD_SEARCH, KEY_MAX, 0, 1'b0, 0),
			ST_FOUND, '0, 4'd8));
		add_row(item_row(CMD_SEARCH, 100, 0, 1'b0, 0));
		add_row(checked_row(item_row(CMD_SEARCH, 101, 0, 1'b0, 0),
			ST_ABSENT, '0, 4'd8));
		add_row(item_row(CMD_SEARCH, KEY_MIN, 0, 1'b0, 0));
		add_row(item_row(CMD_SEARCH, -1, 0, 1'b0, 0));
		add_row(item_row(CMD_SEARCH, 0, 0, 1'b0, 0));
		add_row(checked_row(item_row(CMD_INSERT, KEY_MIN, PTR_ONES, 1'b1, PTR_ONES),
			ST_FULL, '0, 4'd8));
		add_row(leaf_row(1'b0));
		add_row(item_row(CMD_SEARCH, KEY_MAX, 0, 1'b0, 0));

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_table[i]) begin
			if (dir_table[i].kind == ROW_LEAF) write_leaf(dir_table[i].leaf_val);
			else send_item(dir_table[i]);
		end

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			write_leaf(~ph[0]);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 1 && n == PHASE_ITEMS / 2) wait_drained();
				send_item(random_item());
			end
		end

		wait_drained();
		if (errors == 0) $display("PASS slotted_btree_node_engine");
		else $display("FAIL slotted_btree_node_engine");
		$finish;
	end
endmodule
`default_nettype wire

// ===== slotted_btree_node_engine.f =====
rtl/sbn_pkg.sv
rtl/sbn_if.sv
rtl/sbn_ram.sv
rtl/sbn_slots.sv
rtl/slotted_btree_node_engine.sv
bench/tb_top.sv
